// ===== hdl/abs_pkg.sv =====
// abs_pkg: shared types, codes and constants of the alternating-bit sender core
// depends on nothing; imported by every module of the block but abs_ram

package abs_pkg;

   localparam int PAYLOAD_BYTES_DEF = 20;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 48;

   localparam logic [15:0] TIMEOUT_RESET = 16'd50;
   localparam logic [31:0] ACK_DEFAULT   = 32'hFFFF_FFFF;
   localparam logic [1:0]  OUT_ACK_HDR   = 2'b11;

   // input word selector
   localparam logic [1:0] CMD_MSG_BYTE = 2'd0;
   localparam logic [1:0] CMD_RX_BYTE  = 2'd1;
   localparam logic [1:0] CMD_RX_HDR   = 2'd2;
   localparam logic [1:0] CMD_TICK     = 2'd3;

   // result word kind
   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_HDR    = 2'd1;
   localparam logic [1:0] KIND_ACK    = 2'd2;
   localparam logic [1:0] KIND_REFUSE = 2'd3;

   // ack report status
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
   localparam logic [1:0] STATUS_BAD_ACK = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_HDR
   } state_type;

   typedef struct packed {
      logic step;
      logic load_byte;
      logic load_hdr;
      logic idx_clr;
      logic idx_inc;
   } ctrl_type;

   typedef struct packed {
      logic held;
      logic out_free;
      logic send_start;
      logic idx_last;
   } stat_type;

endpackage

// ===== hdl/alternating_bit_sender_core.sv =====
// alternating_bit_sender_core: top level of the alternating-bit sender
// depends on abs_pkg, abs_ctrl, abs_dpath and abs_ram

// Alternating-bit protocol sender. Each input word is caught in a hold register and
// processed in the next free cycle. A word causes no result or a single result
// (refused message, ack report); a message byte that completes a message, or a tick
// that reaches the timeout, also sends the stored packet: PAYLOAD_BYTES payload words
// and then the header word with tlast set, through one fetch state and one load state
// per byte against the registered read port of the packet RAM, then a header state;
// no new word is processed meanwhile. The result register lets the next input word
// be taken while a result waits. The user writes timeout_ticks through
// csr_wr_en/csr_wr_data only while the block is idle; the block does not enforce this.
// A value of zero acts as one. The packet RAM needs no clearing after reset.

module alternating_bit_sender_core #(
   parameter int PAYLOAD_BYTES = abs_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [15:0]                     csr_wr_data,  // timeout_ticks
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // data_byte[7:0], rx_seq_num[39:8], rx_ack_num[71:40], rx_check_value[103:72]
   input  logic [abs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]                      req_tuser,    // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_byte[7:0], out_seq[8], out_ack[10:9], out_check_value[42:11],
   // ack_status[44:43], zero fill[47:45]
   output logic [abs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                      rsp_tuser,    // kind
   output logic                            rsp_tlast     // last
);

   import abs_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   abs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   abs_dpath #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== hdl/abs_ram.sv =====
// abs_ram: generic single-write, single-read RAM with registered read data
// depends on nothing

module abs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 20,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/abs_ctrl.sv =====
// abs_ctrl: controller state machine of the sender, sequences item steps and packet sends
// depends on abs_pkg

module abs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  abs_pkg::stat_type  stat,
   output abs_pkg::ctrl_type  ctrl
);

   import abs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.held && stat.out_free && stat.send_start) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               state_in = stat.idx_last ? ST_HDR : ST_FETCH;
            end
         end
         ST_HDR: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.step    = stat.held && stat.out_free;
            ctrl.idx_clr = 1'b1;
         end
         ST_FETCH: begin
         end
         ST_LOAD: begin
            ctrl.load_byte = stat.out_free;
            ctrl.idx_inc   = stat.out_free && !stat.idx_last;
         end
         ST_HDR: begin
            ctrl.load_hdr = stat.out_free;
         end
         default: ctrl = '0;
      endcase
   end

endmodule

// ===== hdl/abs_dpath.sv =====
// abs_dpath: datapath of the sender: input hold register, protocol state, checksums,
// timer, packet RAM and the result register; depends on abs_pkg and abs_ram

module abs_dpath #(
   parameter int PAYLOAD_BYTES = abs_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  abs_pkg::ctrl_type               ctrl,
   output abs_pkg::stat_type               stat,
   input  logic                            csr_wr_en,
   input  logic [15:0]                     csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [abs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [abs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast
);

   import abs_pkg::*;

   localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int CW = $clog2(PAYLOAD_BYTES + 1);

   // input hold register
   logic                  held_ff, held_in;
   logic [1:0]            h_cmd_ff;
   logic [REQ_DATA_W-1:0] h_data_ff;

   // protocol state
   logic [15:0]   timeout_ff;
   logic          seq_bit_ff, seq_bit_in;
   logic          in_transit_ff, in_transit_in;
   logic [31:0]   saved_chk_ff, saved_chk_in;
   logic          saved_seq_ff, saved_seq_in;
   logic [CW-1:0] msg_count_ff, msg_count_in;
   logic          msg_discard_ff, msg_discard_in;
   logic [31:0]   msg_sum_ff, msg_sum_in;
   logic [31:0]   rx_sum_ff, rx_sum_in;
   logic [CW-1:0] rx_count_ff, rx_count_in;
   logic [15:0]   tick_ff, tick_in;
   logic [AW-1:0] idx_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  r_kind_ff, r_kind_in;
   logic [7:0]  r_byte_ff, r_byte_in;
   logic        r_seq_ff, r_seq_in;
   logic [1:0]  r_ack_ff, r_ack_in;
   logic [31:0] r_chk_ff, r_chk_in;
   logic [1:0]  r_status_ff, r_status_in;
   logic        r_last_ff, r_last_in;
   logic        r_load;

   // step decode
   logic [7:0]    h_byte;
   logic [31:0]   h_seq, h_ack, h_chk, h_byte_sx;
   logic          msg_start, discard_now, refuse, msg_done;
   logic [CW-1:0] count_inc;
   logic [31:0]   msg_sum_now, rx_total;
   logic [16:0]   tick_inc;
   logic [15:0]   limit;
   logic          timeout_hit, send_start;
   logic          ram_we;
   logic [7:0]    ram_rd;
   logic          out_free;

   assign h_byte    = h_data_ff[7:0];
   assign h_seq     = h_data_ff[39:8];
   assign h_ack     = h_data_ff[71:40];
   assign h_chk     = h_data_ff[103:72];
   assign h_byte_sx = {{24{h_byte[7]}}, h_byte};

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !held_ff;

   assign msg_start   = (msg_count_ff == '0);
   assign discard_now = msg_start ? in_transit_ff : msg_discard_ff;
   assign refuse      = msg_start && in_transit_ff;
   assign count_inc   = msg_count_ff + 1'b1;
   assign msg_done    = (count_inc == CW'(PAYLOAD_BYTES));
   assign msg_sum_now = (msg_start ? 32'd0 : msg_sum_ff) + h_byte_sx;
   assign rx_total    = h_seq + h_ack + rx_sum_ff;

   // a zero timeout behaves as one
   assign limit       = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   assign tick_inc    = {1'b0, tick_ff} + 17'd1;
   assign timeout_hit = in_transit_ff && (tick_inc >= {1'b0, limit});

   always_comb begin
      send_start = 1'b0;
      unique case (h_cmd_ff)
         CMD_MSG_BYTE: send_start = !discard_now && msg_done;
         CMD_RX_BYTE:  send_start = 1'b0;
         CMD_RX_HDR:   send_start = 1'b0;
         CMD_TICK:     send_start = timeout_hit;
         default:      send_start = 1'b0;
      endcase
   end

   assign ram_we = ctrl.step && (h_cmd_ff == CMD_MSG_BYTE) && !discard_now;

   abs_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (msg_count_ff[AW-1:0]),
      .wr_data (h_byte),
      .rd_addr (idx_ff),
      .rd_data (ram_rd)
   );

   assign stat.held       = held_ff;
   assign stat.out_free   = out_free;
   assign stat.send_start = send_start;
   assign stat.idx_last   = (idx_ff == AW'(PAYLOAD_BYTES - 1));

   // protocol state update on a step
   always_comb begin
      seq_bit_in     = seq_bit_ff;
      in_transit_in  = in_transit_ff;
      saved_chk_in   = saved_chk_ff;
      saved_seq_in   = saved_seq_ff;
      msg_count_in   = msg_count_ff;
      msg_discard_in = msg_discard_ff;
      msg_sum_in     = msg_sum_ff;
      rx_sum_in      = rx_sum_ff;
      rx_count_in    = rx_count_ff;
      tick_in        = tick_ff;
      if (ctrl.step) begin
         unique case (h_cmd_ff)
            CMD_MSG_BYTE: begin
               msg_discard_in = discard_now;
               if (!discard_now) begin
                  msg_sum_in = msg_sum_now;
               end
               msg_count_in = msg_done ? '0 : count_inc;
               if (msg_done && !discard_now) begin
                  saved_chk_in  = msg_sum_now + {31'd0, seq_bit_ff} + ACK_DEFAULT;
                  saved_seq_in  = seq_bit_ff;
                  in_transit_in = 1'b1;
                  tick_in       = 16'd0;
               end
            end
            CMD_RX_BYTE: begin
               if (rx_count_ff < CW'(PAYLOAD_BYTES)) begin
                  rx_sum_in   = rx_sum_ff + h_byte_sx;
                  rx_count_in = rx_count_ff + 1'b1;
               end
            end
            CMD_RX_HDR: begin
               rx_sum_in   = 32'd0;
               rx_count_in = '0;
               if (rx_total == h_chk && h_ack == {31'd0, seq_bit_ff}) begin
                  seq_bit_in    = !seq_bit_ff;
                  in_transit_in = 1'b0;
                  tick_in       = 16'd0;
               end
            end
            CMD_TICK: begin
               if (in_transit_ff) begin
                  tick_in = timeout_hit ? 16'd0 : tick_inc[15:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result register loads
   always_comb begin
      r_load      = 1'b0;
      r_kind_in   = KIND_BYTE;
      r_byte_in   = 8'd0;
      r_seq_in    = 1'b0;
      r_ack_in    = 2'd0;
      r_chk_in    = 32'd0;
      r_status_in = STATUS_OK;
      r_last_in   = 1'b1;
      if (ctrl.step && h_cmd_ff == CMD_MSG_BYTE && refuse) begin
         r_load    = 1'b1;
         r_kind_in = KIND_REFUSE;
      end else if (ctrl.step && h_cmd_ff == CMD_RX_HDR) begin
         r_load    = 1'b1;
         r_kind_in = KIND_ACK;
         if (rx_total != h_chk) begin
            r_status_in = STATUS_BAD_SUM;
         end else if (h_ack != {31'd0, seq_bit_ff}) begin
            r_status_in = STATUS_BAD_ACK;
         end
      end else if (ctrl.load_byte) begin
         r_load    = 1'b1;
         r_kind_in = KIND_BYTE;
         r_byte_in = ram_rd;
         r_last_in = 1'b0;
      end else if (ctrl.load_hdr) begin
         r_load    = 1'b1;
         r_kind_in = KIND_HDR;
         r_seq_in  = saved_seq_ff;
         r_ack_in  = OUT_ACK_HDR;
         r_chk_in  = saved_chk_ff;
      end
   end

   assign held_in      = (req_tvalid && req_tready) || (held_ff && !ctrl.step);
   assign rsp_valid_in = r_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff        <= 1'b0;
         timeout_ff     <= TIMEOUT_RESET;
         seq_bit_ff     <= 1'b0;
         in_transit_ff  <= 1'b0;
         saved_chk_ff   <= 32'd0;
         saved_seq_ff   <= 1'b0;
         msg_count_ff   <= '0;
         msg_discard_ff <= 1'b0;
         msg_sum_ff     <= 32'd0;
         rx_sum_ff      <= 32'd0;
         rx_count_ff    <= '0;
         tick_ff        <= 16'd0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         held_ff        <= held_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         seq_bit_ff     <= seq_bit_in;
         in_transit_ff  <= in_transit_in;
         saved_chk_ff   <= saved_chk_in;
         saved_seq_ff   <= saved_seq_in;
         msg_count_ff   <= msg_count_in;
         msg_discard_ff <= msg_discard_in;
         msg_sum_ff     <= msg_sum_in;
         rx_sum_ff      <= rx_sum_in;
         rx_count_ff    <= rx_count_in;
         tick_ff        <= tick_in;
         if (ctrl.idx_clr) begin
            idx_ff <= '0;
         end else if (ctrl.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         h_cmd_ff  <= req_tuser;
         h_data_ff <= req_tdata;
      end
      if (r_load) begin
         r_kind_ff   <= r_kind_in;
         r_byte_ff   <= r_byte_in;
         r_seq_ff    <= r_seq_in;
         r_ack_ff    <= r_ack_in;
         r_chk_ff    <= r_chk_in;
         r_status_ff <= r_status_in;
         r_last_ff   <= r_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = r_kind_ff;
   assign rsp_tlast  = r_last_ff;
   assign rsp_tdata  = {3'd0, r_status_ff, r_chk_ff, r_ack_ff, r_seq_ff, r_byte_ff};

endmodule

// ===== hdl/abs_checker.sv =====
// abs_checker: port-level assertions on the result channel of the sender core
// depends on abs_pkg; bound to alternating_bit_sender_core below

module abs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [abs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tlast
);

   import abs_pkg::*;

   // only payload words of a packet leave tlast low
   a_last_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_BYTE)))
      else $error("tlast does not match result kind");

   // header word carries ack -1 and no payload byte
   a_hdr_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_HDR) |->
         (rsp_tdata[10:9] == OUT_ACK_HDR && rsp_tdata[7:0] == 8'd0 &&
          rsp_tdata[44:43] == STATUS_OK))
      else $error("bad header word fields");

   // payload word has clear header and status fields
   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_BYTE) |-> (rsp_tdata[47:8] == 40'd0))
      else $error("payload word has stray header bits");

   // a stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result word changed");

endmodule

bind alternating_bit_sender_core abs_checker u_abs_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for alternating_bit_sender_core: a directed table, then random link
// traffic over several timeout settings, every result word checked against an in-bench model
// depends on abs_pkg and the alternating_bit_sender_core rtl

module tb;
   import abs_pkg::*;

   localparam int PAYLOAD    = PAYLOAD_BYTES_DEF;
   localparam int N_DIRECTED = 17;

   typedef enum logic [1:0] {FROM_MODEL, NO_WORD, ONE_WORD} row_check_type;

   typedef struct packed {
      logic [1:0]    cmd;
      logic [7:0]    data;
      logic [31:0]   seq;
      logic [31:0]   ack;
      logic [31:0]   chk;
      row_check_type check;
      logic [1:0]    kind;
      logic [1:0]    status;
   } dir_row_type;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        seq;
      logic [1:0]  ack;
      logic [31:0] chk;
      logic [1:0]  status;
      logic        last;
   } link_word_type;

   // directed rows start right after reset: seq bit 0, nothing in transit
   localparam dir_row_type DIRECTED [N_DIRECTED] = '{
      '{CMD_TICK,   8'h80, 32'h0,         32'h0,         32'h0,         NO_WORD,
        KIND_BYTE, STATUS_OK},
      '{CMD_TICK,   8'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NO_WORD,
        KIND_BYTE, STATUS_OK},
      // matching ack with nothing in transit still flips the bit
      '{CMD_RX_HDR, 8'h00, 32'h0,         32'h0,         32'h0,         ONE_WORD,
        KIND_ACK,  STATUS_OK},
      '{CMD_RX_HDR, 8'h00, 32'h0,         32'h0,         32'h0,         ONE_WORD,
        KIND_ACK,  STATUS_BAD_ACK},
      '{CMD_RX_HDR, 8'h00, 32'h0,         32'h5,         32'h0,         ONE_WORD,
        KIND_ACK,  STATUS_BAD_SUM},
      '{CMD_RX_HDR, 8'h00, 32'h0,         32'h1,         32'h1,         ONE_WORD,
        KIND_ACK,  STATUS_OK},
      '{CMD_RX_BYTE, 8'h7F, 32'h0,        32'h0,         32'h0,         NO_WORD,
        KIND_BYTE, STATUS_OK},
      '{CMD_RX_BYTE, 8'h80, 32'h0,        32'h0,         32'h0,         NO_WORD,
        KIND_BYTE, STATUS_OK},
      '{CMD_RX_BYTE, 8'hFF, 32'h0,        32'h0,         32'h0,         NO_WORD,
        KIND_BYTE, STATUS_OK},
      '{CMD_RX_HDR, 8'h00, 32'h7FFF_FFFF, 32'h0,         32'h7FFF_FFFD, FROM_MODEL,
        KIND_ACK,  STATUS_OK},
      // checksum wraps, ack of all ones is compared at full width
      '{CMD_RX_HDR, 8'h00, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, FROM_MODEL,
        KIND_ACK,  STATUS_OK},
      '{CMD_RX_HDR, 8'h00, 32'hFFFF_FFFF, 32'h1,         32'h0,         FROM_MODEL,
        KIND_ACK,  STATUS_OK},
      // header clears the byte sum, so this one is off by one
      '{CMD_RX_HDR, 8'h00, 32'h0,         32'h0,         32'h1,         ONE_WORD,
        KIND_ACK,  STATUS_BAD_SUM},
      '{CMD_RX_HDR, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, FROM_MODEL,
        KIND_ACK,  STATUS_OK},
      '{CMD_RX_HDR, 8'h00, 32'h1,         32'h0,         32'h1,         FROM_MODEL,
        KIND_ACK,  STATUS_OK},
      '{CMD_TICK,   8'h00, 32'h0,         32'h0,         32'h0,         NO_WORD,
        KIND_BYTE, STATUS_OK},
      '{CMD_RX_HDR, 8'h00, 32'hFFFF_FFFE, 32'h1,         32'hFFFF_FFFF, FROM_MODEL,
        KIND_ACK,  STATUS_OK}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [15:0]           csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [1:0]            req_tuser   = CMD_MSG_BYTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   // sender model state
   logic [15:0] timeout_cfg;
   logic        cur_seq, in_flight, msg_drop, pkt_seq;
   logic [7:0]  pkt_mem [PAYLOAD];
   logic [31:0] pkt_sum, rx_acc;
   int unsigned msg_idx, rx_len, tick_cnt;

   link_word_type words_due [$];

   int fault_count, words_in, words_out, packets_out, refusals, acks_out, settings_run;
   int phase_items, src_burst, sink_burst, hold_off_cycles;

   alternating_bit_sender_core #(
      .PAYLOAD_BYTES(PAYLOAD)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] sext8(input logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   function automatic void push_word(input logic [1:0] kind, input logic [7:0] data,
                                     input logic seq, input logic [1:0] ack,
                                     input logic [31:0] chk, input logic [1:0] status,
                                     input logic last);
      link_word_type w;
      w.kind   = kind;
      w.data   = data;
      w.seq    = seq;
      w.ack    = ack;
      w.chk    = chk;
      w.status = status;
      w.last   = last;
      words_due.push_back(w);
   endfunction

   function automatic void queue_packet();
      int i;
      for (i = 0; i < PAYLOAD; i++)
         push_word(KIND_BYTE, pkt_mem[i], 1'b0, 2'b00, 32'h0, STATUS_OK, 1'b0);
      push_word(KIND_HDR, 8'h00, pkt_seq, OUT_ACK_HDR, pkt_sum, STATUS_OK, 1'b1);
   endfunction

   // next result words of the sender for one accepted word
   function automatic void predict_sender(input logic [1:0] cmd, input logic [7:0] data,
                                          input logic [31:0] rs, input logic [31:0] ra,
                                          input logic [31:0] rc);
      logic [31:0] sum;
      logic [15:0] limit;
      int i;
      case (cmd)
         CMD_MSG_BYTE: begin
            // first byte decides take or refuse for the whole message
            if (msg_idx == 0) begin
               msg_drop = in_flight;
               if (in_flight)
                  push_word(KIND_REFUSE, 8'h00, 1'b0, 2'b00, 32'h0, STATUS_OK, 1'b1);
            end
            if (!msg_drop) pkt_mem[msg_idx] = data;
            msg_idx++;
            if (msg_idx >= PAYLOAD) begin
               msg_idx = 0;
               if (!msg_drop) begin
                  sum = ACK_DEFAULT + {31'b0, cur_seq};
                  for (i = 0; i < PAYLOAD; i++) sum += sext8(pkt_mem[i]);
                  pkt_sum   = sum;
                  pkt_seq   = cur_seq;
                  in_flight = 1'b1;
                  tick_cnt  = 0;
                  queue_packet();
               end
            end
         end
         CMD_RX_BYTE: begin
            if (rx_len < PAYLOAD) begin
               rx_acc += sext8(data);
               rx_len++;
            end
         end
         CMD_RX_HDR: begin
            sum    = rs + ra + rx_acc;
            rx_acc = 0;
            rx_len = 0;
            if (sum != rc) begin
               push_word(KIND_ACK, 8'h00, 1'b0, 2'b00, 32'h0, STATUS_BAD_SUM, 1'b1);
            end else if (ra != {31'b0, cur_seq}) begin
               push_word(KIND_ACK, 8'h00, 1'b0, 2'b00, 32'h0, STATUS_BAD_ACK, 1'b1);
            end else begin
               cur_seq   = ~cur_seq;
               in_flight = 1'b0;
               tick_cnt  = 0;
               push_word(KIND_ACK, 8'h00, 1'b0, 2'b00, 32'h0, STATUS_OK, 1'b1);
            end
         end
         CMD_TICK: begin
            if (in_flight) begin
               limit = (timeout_cfg == 16'd0) ? 16'd1 : timeout_cfg;
               tick_cnt++;
               if (tick_cnt >= limit) begin
                  tick_cnt = 0;
                  queue_packet();
               end
            end
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 5) != 0) return 8'($urandom);
      case ($urandom_range(0, 3))
         0:       return 8'h7F;
         1:       return 8'h80;
         2:       return 8'h00;
         default: return 8'hFF;
      endcase
   endfunction

   // called at a rising edge, returns at the edge where the word was taken
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] data,
                            input logic [31:0] rs, input logic [31:0] ra,
                            input logic [31:0] rc);
      int gap;
      if (src_burst > 0) begin
         gap = 0;
         src_burst--;
      end else if ($urandom_range(0, 15) == 0) begin
         gap = 0;
         src_burst = $urandom_range(10, 30);
      end else begin
         gap = $urandom_range(0, 12);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {rc, ra, rs, data};
      do @(posedge clock); while (req_tready !== 1'b1);
      words_in++;
   endtask

   task automatic feed(input logic [1:0] cmd, input logic [7:0] data,
                       input logic [31:0] rs, input logic [31:0] ra, input logic [31:0] rc);
      phase_items++;
      send_word(cmd, data, rs, ra, rc);
      predict_sender(cmd, data, rs, ra, rc);
   endtask

   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] value);
      settle(8);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      timeout_cfg = value;
      settings_run++;
   endtask

   task automatic run_phase(input int target);
      int pick, n, i;
      logic [31:0] rs, ra, chk;
      logic [15:0] eff;
      phase_items = 0;
      while (phase_items < target) begin
         pick = $urandom_range(0, 99);
         eff  = (timeout_cfg == 16'd0) ? 16'd1 : timeout_cfg;
         if (pick < 10) begin
            feed(2'($urandom_range(0, 3)), 8'($urandom), $urandom, $urandom, $urandom);
         end else if (pick < 50) begin
            // whole message; refused if a packet is still in transit
            for (i = 0; i < PAYLOAD; i++)
               feed(CMD_MSG_BYTE, pick_byte(), 32'h0, 32'h0, 32'h0);
         end else if (pick < 72) begin
            n = (in_flight && eff <= 16'd8) ? $urandom_range(1, eff + 1) : $urandom_range(1, 3);
            for (i = 0; i < n; i++)
               feed(CMD_TICK, 8'($urandom), $urandom, $urandom, $urandom);
         end else begin
            // arriving packet, mostly short, now and then past the payload size
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(PAYLOAD - 2, PAYLOAD + 3)
                                             : $urandom_range(0, 3);
            for (i = 0; i < n; i++)
               feed(CMD_RX_BYTE, pick_byte(), $urandom, $urandom, $urandom);
            rs  = $urandom;
            ra  = ($urandom_range(0, 9) < 7) ? {31'b0, cur_seq} : $urandom;
            chk = rs + ra + rx_acc;
            if ($urandom_range(0, 3) == 0) chk ^= 32'h1 << $urandom_range(0, 31);
            feed(CMD_RX_HDR, 8'($urandom), rs, ra, chk);
         end
      end
   endtask

   // result side: random stalls, bursts of full rate, and on request one long hold
   initial begin : result_sink
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            gap = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (sink_burst > 0) begin
            gap = 0;
            sink_burst--;
         end else if ($urandom_range(0, 15) == 0) begin
            gap = 0;
            sink_burst = $urandom_range(10, 40);
         end else begin
            gap = $urandom_range(0, 12);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1 && hold_off_cycles == 0);
      end
   end

   always @(posedge clock) begin : result_check
      link_word_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         words_out++;
         case (rsp_tuser)
            KIND_HDR:    packets_out++;
            KIND_REFUSE: refusals++;
            KIND_ACK:    acks_out++;
            default:     ;
         endcase
         if (words_due.size() == 0) begin
            note_fault($sformatf("unexpected result word %0d: kind %0d data %h last %b",
                                 words_out, rsp_tuser, rsp_tdata, rsp_tlast));
         end else begin
            want = words_due.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[7:0] !== want.data ||
                rsp_tdata[8] !== want.seq || rsp_tdata[10:9] !== want.ack ||
                rsp_tdata[42:11] !== want.chk || rsp_tdata[44:43] !== want.status ||
                rsp_tdata[47:45] !== 3'b000 || rsp_tlast !== want.last)
               note_fault($sformatf({"result word %0d: exp kind %0d byte %h seq %b ack %b ",
                                     "chk %h st %0d last %b, got kind %0d byte %h seq %b ",
                                     "ack %b chk %h st %0d pad %b last %b"},
                                    words_out, want.kind, want.data, want.seq, want.ack,
                                    want.chk, want.status, want.last, rsp_tuser,
                                    rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[10:9],
                                    rsp_tdata[42:11], rsp_tdata[44:43], rsp_tdata[47:45],
                                    rsp_tlast));
         end
      end
   end

   initial begin : stimulus
      int k, base;
      timeout_cfg = TIMEOUT_RESET;
      cur_seq     = 1'b0;
      in_flight   = 1'b0;
      msg_drop    = 1'b0;
      pkt_seq     = 1'b0;
      pkt_sum     = '0;
      rx_acc      = '0;
      msg_idx     = 0;
      rx_len      = 0;
      tick_cnt    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < N_DIRECTED; k++) begin
         send_word(DIRECTED[k].cmd, DIRECTED[k].data, DIRECTED[k].seq, DIRECTED[k].ack,
                   DIRECTED[k].chk);
         base = words_due.size();
         predict_sender(DIRECTED[k].cmd, DIRECTED[k].data, DIRECTED[k].seq,
                        DIRECTED[k].ack, DIRECTED[k].chk);
         // typed rows replace what the model queued, model state still advances
         if (DIRECTED[k].check != FROM_MODEL) begin
            while (words_due.size() > base) void'(words_due.pop_back());
            if (DIRECTED[k].check == ONE_WORD)
               push_word(DIRECTED[k].kind, 8'h00, 1'b0, 2'b00, 32'h0, DIRECTED[k].status,
                         1'b1);
         end
      end

      set_timeout(16'd3);
      hold_off_cycles = 300;
      run_phase(20);
      set_timeout(16'd1);
      run_phase(10);
      set_timeout(16'd0);
      run_phase(10);
      set_timeout(16'hFFFF);
      run_phase(10);
      set_timeout(16'($urandom_range(2, 9)));
      run_phase(10);
      settle(2 * PAYLOAD + 20);

      $display("summary: %0d input words over %0d timeout settings after the reset value",
               words_in, settings_run);
      $display("summary: %0d result words, %0d packets sent or resent, %0d refusals, %0d acks",
               words_out, packets_out, refusals, acks_out);
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches in total", fault_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("timeout with %0d result words still due", words_due.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/abs_pkg.sv
hdl/abs_ram.sv
hdl/abs_ctrl.sv
hdl/abs_dpath.sv
hdl/alternating_bit_sender_core.sv
hdl/abs_checker.sv
dv/tb.sv
